[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit.
// Holds the operation codes, the item structs and the pipeline record types.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  localparam int DW = 16;
  localparam int FB = 8;
  // Product width and divider geometry.
  localparam int PW = 2 * DW + 2;
  // Quotient steps: one per numerator bit (PW) plus the fraction bits.
  localparam int QSTEPS = PW + FB;
  localparam int QW = DW + 2;

  typedef struct packed {
    func_t              func;
    logic signed [DW-1:0] left_re;
    logic signed [DW-1:0] left_im;
    logic signed [DW-1:0] right_re;
    logic signed [DW-1:0] right_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 overflow;
    logic                 div_zero;
  } out_item_t;

  // One divider lane state handed from cell to cell.
  typedef struct packed {
    logic          neg;
    logic [PW-1:0] num;
    logic [PW:0]   rem;
    logic [QW-1:0] q;
  } lane_t;

  // Record passed down the chain of cells.
  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic          dz;
    logic [PW-1:0] den;
    lane_t         re;
    lane_t         im;
  } cell_rec_t;

endpackage

`default_nettype wire

[sv/cau_cell.sv]
// ----------------------------------------------------------------------------
// cau_cell: one restoring division step for both parts of a record.
// Brings in one numerator bit, conditionally subtracts the divisor and
// shifts the quotient bit in, with a sticky cap just above the signed range.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_cell (
  input  wire              clk,
  input  wire              rst,
  input  cau_pkg::cell_rec_t rec_in,
  output cau_pkg::cell_rec_t rec_out
);
  import cau_pkg::*;

  localparam logic [QW-1:0] QCAP = QW'(1) << (DW - 1);

  cell_rec_t rec_next;

  function automatic lane_t step(input lane_t l, input logic [PW-1:0] den);
    logic [PW:0]   r2;
    logic [PW:0]   dif;
    logic          bit_q;
    logic [QW:0]   q2;
    lane_t         o;
    r2    = {l.rem[PW-1:0], l.num[PW-1]};
    dif   = r2 - {1'b0, den};
    bit_q = (r2 >= {1'b0, den});
    o     = l;
    o.num = {l.num[PW-2:0], 1'b0};
    o.rem = bit_q ? dif : r2;
    q2    = {l.q, bit_q};
    // Once the quotient passes the cap it stays pinned above it.
    if (q2 > {1'b0, QCAP}) o.q = QCAP + QW'(1);
    else o.q = q2[QW-1:0];
    return o;
  endfunction

  // Apply one step to each lane.
  always_comb begin
    rec_next    = rec_in;
    rec_next.re = step(rec_in.re, rec_in.den);
    rec_next.im = step(rec_in.im, rec_in.den);
  end

  // Hand the record to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else begin
      rec_out.valid <= rec_in.valid;
    end
    rec_out.is_div <= rec_next.is_div;
    rec_out.dz     <= rec_next.dz;
    rec_out.den    <= rec_next.den;
    rec_out.re     <= rec_next.re;
    rec_out.im     <= rec_next.im;
  end

endmodule

`default_nettype wire

[sv/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit: complex add, subtract, multiply and divide in Q7.8.
//
//   channel  | ports                        | handshake
//   ---------+------------------------------+---------------------------
//   input    | in_item                      | start high, busy low
//   result   | out_item                     | done high for one cycle
//
// One item may enter every cycle; busy is held low. Every item, whatever
// its operation, passes 45 register stages: one for the products and sums,
// one for the head of the chain, one restoring division step per cell in a
// chain of 42 cells (34 numerator bits plus 8 fraction bits), and a final
// output register; done is registered alongside the result.
// Reset is synchronous and clears the valid bits of the pipeline only.
// The receiver cannot stall, so nothing ever holds the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  cau_pkg::in_item_t   in_item,
  output logic                done,
  output cau_pkg::out_item_t  out_item
);
  import cau_pkg::*;

  localparam int NCELL = QSTEPS;
  localparam logic [PW-1:0] HALF = PW'(1) << (DW - 1);

  // Stage 1: products and sums.
  logic                    s1_valid;
  func_t                   s1_func;
  logic signed [DW:0]      s1_sre, s1_sim;
  logic signed [2*DW-1:0]  p_rr, p_ii, p_ri, p_ir;
  logic [2*DW-1:0]         p_mr, p_mi;

  // Stage 2: exact values as sign and magnitude.
  cell_rec_t               chain [0:NCELL];
  logic [NCELL:0]          sh_sel;
  logic [NCELL:0]          sh_mul;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_func <= in_item.func;
    s1_sre  <= (in_item.func == FUNC_SUB)
               ? (DW+1)'(in_item.left_re) - (DW+1)'(in_item.right_re)
               : (DW+1)'(in_item.left_re) + (DW+1)'(in_item.right_re);
    s1_sim  <= (in_item.func == FUNC_SUB)
               ? (DW+1)'(in_item.left_im) - (DW+1)'(in_item.right_im)
               : (DW+1)'(in_item.left_im) + (DW+1)'(in_item.right_im);
    p_rr <= in_item.left_re * in_item.right_re;
    p_ii <= in_item.left_im * in_item.right_im;
    p_ri <= in_item.left_re * in_item.right_im;
    p_ir <= in_item.left_im * in_item.right_re;
    p_mr <= in_item.right_re * in_item.right_re;
    p_mi <= in_item.right_im * in_item.right_im;
  end

  // Exact combinations of the products, or the sums for add and subtract.
  logic signed [PW-1:0] v_re, v_im;
  logic [PW-1:0]        den;
  always_comb begin
    den = PW'(p_mr) + PW'(p_mi);
    case (s1_func)
      FUNC_MUL: begin
        v_re = PW'(p_rr) - PW'(p_ii);
        v_im = PW'(p_ri) + PW'(p_ir);
      end
      FUNC_DIV: begin
        v_re = PW'(p_rr) + PW'(p_ii);
        v_im = PW'(p_ir) - PW'(p_ri);
      end
      default: begin
        v_re = PW'(s1_sre);
        v_im = PW'(s1_sim);
      end
    endcase
  end

  // Load the head of the chain. The cells shift num, so non-divide items
  // keep their magnitudes in the side copies below.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= s1_valid;
    end
    chain[0].is_div <= (s1_func == FUNC_DIV);
    chain[0].dz     <= (s1_func == FUNC_DIV) && (den == '0);
    chain[0].den    <= den;
    chain[0].re.neg <= v_re[PW-1];
    chain[0].im.neg <= v_im[PW-1];
    chain[0].re.num <= v_re[PW-1] ? PW'(-v_re) : v_re;
    chain[0].im.num <= v_im[PW-1] ? PW'(-v_im) : v_im;
    chain[0].re.rem <= '0;
    chain[0].im.rem <= '0;
    chain[0].re.q   <= '0;
    chain[0].im.q   <= '0;
    sh_sel[0]       <= (s1_func == FUNC_DIV);
    sh_mul[0]       <= (s1_func == FUNC_MUL);
  end

  // Side copies of the original magnitudes for non-divide items.
  logic [PW-1:0] keep_re [0:NCELL];
  logic [PW-1:0] keep_im [0:NCELL];
  always_ff @(posedge clk) begin
    keep_re[0] <= v_re[PW-1] ? PW'(-v_re) : v_re;
    keep_im[0] <= v_im[PW-1] ? PW'(-v_im) : v_im;
  end

  genvar g;
  generate
    for (g = 0; g < NCELL; g++) begin : g_cell
      cau_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .rec_in  (chain[g]),
        .rec_out (chain[g+1])
      );
      always_ff @(posedge clk) begin
        keep_re[g+1]  <= keep_re[g];
        keep_im[g+1]  <= keep_im[g];
        sh_sel[g+1]   <= sh_sel[g];
        sh_mul[g+1]   <= sh_mul[g];
      end
    end
  endgenerate

  // Final scaling, quotient pick and saturation.
  cell_rec_t last;
  logic [PW-1:0] m_re, m_im;
  logic [DW-1:0] o_re, o_im;
  logic          ov_re, ov_im;

  function automatic logic [PW-1:0] floor_mag(input logic [PW-1:0] m,
                                               input logic neg, input logic mul);
    logic [PW-1:0] r;
    if (!mul) r = m;
    else if (neg) r = (m + PW'((1 << FB) - 1)) >> FB;
    else r = m >> FB;
    return r;
  endfunction

  function automatic logic [DW:0] sat(input logic [PW-1:0] m, input logic neg);
    logic [DW:0] r;
    if (m == '0) r = '0;
    else if (neg) begin
      if (m > HALF) r = {1'b1, 1'b1, {(DW-1){1'b0}}};
      else r = {1'b0, DW'(-m)};
    end else begin
      if (m > HALF - PW'(1)) r = {1'b1, 1'b0, {(DW-1){1'b1}}};
      else r = {1'b0, m[DW-1:0]};
    end
    return r;
  endfunction

  logic [DW:0] sr, si;
  always_comb begin
    last = chain[NCELL];
    m_re = sh_sel[NCELL] ? PW'(last.re.q) :
           floor_mag(keep_re[NCELL], last.re.neg, sh_mul[NCELL]);
    m_im = sh_sel[NCELL] ? PW'(last.im.q) :
           floor_mag(keep_im[NCELL], last.im.neg, sh_mul[NCELL]);
    sr = sat(m_re, last.re.neg);
    si = sat(m_im, last.im.neg);
    ov_re = sr[DW];
    ov_im = si[DW];
    o_re  = sr[DW-1:0];
    o_im  = si[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    if (last.dz) begin
      out_item.res_re   <= '0;
      out_item.res_im   <= '0;
      out_item.overflow <= 1'b0;
      out_item.div_zero <= 1'b1;
    end else begin
      out_item.res_re   <= o_re;
      out_item.res_im   <= o_im;
      out_item.overflow <= ov_re | ov_im;
      out_item.div_zero <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // An item never leaves without having entered the chain.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(last.valid))
    else $error("result strobe without an item at the end of the chain");

  // Divide-by-zero only for divide items.
  a_dz_div: assert property (@(posedge clk) disable iff (rst)
    (chain[0].valid && chain[0].dz) |-> chain[0].is_div)
    else $error("zero-divisor flag on a non-divide item");

  // A zero-divisor result carries no overflow.
  a_dz_ovf: assert property (@(posedge clk) disable iff (rst)
    (done && out_item.div_zero) |-> !out_item.overflow)
    else $error("overflow raised with zero divisor");
`endif

endmodule

`default_nettype wire

[tb/sv/complex_arith_unit_test.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit_test: self-checking bench for the complex arithmetic unit.
// A table of directed items goes first. Then random add, subtract, multiply
// and divide items follow, operands biased toward extremes and small values.
// Each result is compared, in issue order through a queue, with a typed value
// from the table or a software model of the Q7.8 arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cau_pkg::*;

  localparam int MAXV = 32767;
  localparam int MINV = -32768;
  localparam int N_RANDOM = 1700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  in_item_t in_item = '0;
  out_item_t out_item;

  complex_arith_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Results still owed by the unit, oldest first.
  out_item_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned issued_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned func_seen[4] = '{0, 0, 0, 0};
  int unsigned dz_seen = 0;
  int unsigned ovf_seen = 0;

  // Clamp a wide signed value to 16 bits, noting saturation.
  function automatic logic signed [15:0] clamp16(input longint v, inout bit ovf);
    if (v > MAXV) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < MINV) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Quotient (num * 256) / den, truncated toward zero.
  function automatic longint quot_q8(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 256) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Expected result of one item.
  function automatic out_item_t complex_result(input in_item_t it);
    out_item_t r;
    longint lr, li, rr, ri, vre, vim, den;
    bit ovf;
    lr = it.left_re;
    li = it.left_im;
    rr = it.right_re;
    ri = it.right_im;
    ovf = 1'b0;
    r = '0;
    case (it.func)
      FUNC_ADD: begin
        vre = lr + rr;
        vim = li + ri;
      end
      FUNC_SUB: begin
        vre = lr - rr;
        vim = li - ri;
      end
      FUNC_MUL: begin
        vre = (lr * rr - li * ri) >>> 8;
        vim = (lr * ri + li * rr) >>> 8;
      end
      default: begin
        den = rr * rr + ri * ri;
        if (den == 0) begin
          r.div_zero = 1'b1;
          return r;
        end
        vre = quot_q8(lr * rr + li * ri, den);
        vim = quot_q8(li * rr - lr * ri, den);
      end
    endcase
    r.res_re = clamp16(vre, ovf);
    r.res_im = clamp16(vim, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  // Operand value biased toward the extremes and small magnitudes.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 511)) - 16'd256;
      4: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed table; check_typed marks rows whose result is written out.
  typedef struct {
    in_item_t  item;
    bit        check_typed;
    out_item_t result;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic directed_row_t make_row(input func_t f, input int a, input int b,
                                             input int c, input int d, input bit typed,
                                             input int xr, input int xi, input bit xo,
                                             input bit xz);
    directed_row_t row;
    row.item.func = f;
    row.item.left_re = a[15:0];
    row.item.left_im = b[15:0];
    row.item.right_re = c[15:0];
    row.item.right_im = d[15:0];
    row.check_typed = typed;
    row.result.res_re = xr[15:0];
    row.result.res_im = xi[15:0];
    row.result.overflow = xo;
    row.result.div_zero = xz;
    return row;
  endfunction

  initial begin
    directed_rows.push_back(make_row(FUNC_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_ADD, MAXV, MINV, MAXV, MINV, 1, MAXV, MINV, 1, 0));
    directed_rows.push_back(make_row(FUNC_ADD, MAXV, MINV, 0, 0, 1, MAXV, MINV, 0, 0));
    directed_rows.push_back(make_row(FUNC_ADD, 1, -1, -1, 1, 1, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_SUB, MINV, MAXV, 1, -1, 1, MINV, MAXV, 1, 0));
    directed_rows.push_back(make_row(FUNC_SUB, MAXV, MINV, MAXV, MINV, 1, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_SUB, 0, 0, MINV, MINV, 1, MAXV, MAXV, 1, 0));
    directed_rows.push_back(make_row(FUNC_MUL, 256, 0, 256, 0, 1, 256, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_MUL, 0, 256, 0, 256, 1, -256, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_MUL, MAXV, MAXV, MAXV, MAXV, 1, 0, MAXV, 1, 0));
    directed_rows.push_back(make_row(FUNC_MUL, MINV, MINV, MINV, MINV, 1, 0, MAXV, 1, 0));
    directed_rows.push_back(make_row(FUNC_MUL, -1, 0, 1, 0, 1, -1, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_MUL, MINV, MAXV, MAXV, MINV, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_DIV, 1234, -77, 0, 0, 1, 0, 0, 0, 1));
    directed_rows.push_back(make_row(FUNC_DIV, MAXV, MINV, 0, 0, 1, 0, 0, 0, 1));
    directed_rows.push_back(make_row(FUNC_DIV, 256, 0, 256, 0, 1, 256, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_DIV, MAXV, MAXV, 1, 0, 1, MAXV, MAXV, 1, 0));
    directed_rows.push_back(make_row(FUNC_DIV, MINV, MINV, 0, 1, 1, MINV, MAXV, 1, 0));
    directed_rows.push_back(make_row(FUNC_DIV, -1, 1, MAXV, MAXV, 1, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_DIV, MINV, MAXV, MINV, MINV, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_DIV, 100, 200, 3, -7, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_row(FUNC_DIV, -300, 5, -1, 0, 0, 0, 0, 0, 0));
  end

  // Offer one item and hold it until the unit takes it.
  task automatic issue_item(input in_item_t it, input out_item_t want, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
    issued_count++;
    func_seen[it.func]++;
  endtask

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      result_count++;
      if (out_item.div_zero) dz_seen++;
      if (out_item.overflow) ovf_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result re=%0d im=%0d", out_item.res_re,
                   out_item.res_im);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d expected re=%0d im=%0d ovf=%0b dz=%0b, got re=%0d im=%0d ovf=%0b dz=%0b",
                     result_count, want.res_re, want.res_im, want.overflow, want.div_zero,
                     out_item.res_re, out_item.res_im, out_item.overflow, out_item.div_zero);
        end
      end
    end
  end

  // Watchdog on cycles with no item or result accepted.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: watchdog expired with %0d results owed", pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    in_item_t it;
    out_item_t want;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows.
    foreach (directed_rows[i]) begin
      want = directed_rows[i].check_typed ? directed_rows[i].result
                                          : complex_result(directed_rows[i].item);
      issue_item(directed_rows[i].item, want, 1'b1);
    end

    // Random items; the last part runs with no gaps.
    for (int n = 0; n < N_RANDOM; n++) begin
      it.func = func_t'($urandom_range(0, 3));
      it.left_re = pick_operand();
      it.left_im = pick_operand();
      it.right_re = pick_operand();
      it.right_im = pick_operand();
      if (it.func == FUNC_DIV && $urandom_range(0, 19) == 0) begin
        it.right_re = '0;
        it.right_im = '0;
      end
      issue_item(it, complex_result(it), n < N_RANDOM - 300);
    end
    start <= 1'b0;

    // Drain outstanding results, then a short settle.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Issued %0d items (add %0d, sub %0d, mul %0d, div %0d); checked %0d results.",
             issued_count, func_seen[0], func_seen[1], func_seen[2], func_seen[3],
             result_count);
    $display("Saw %0d saturated results and %0d zero-divisor results; %0d mismatches.",
             ovf_seen, dz_seen, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
